/* hw/rtl/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types, constants and helper functions for the card classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

    // Number format
    localparam int CARD_W        = 63;                       // binary card number
    localparam int BITS_PER_STEP = 4;                        // binary bits per dabble step
    localparam int DABBLE_STEPS  = (CARD_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int BIN_W         = DABBLE_STEPS * BITS_PER_STEP;
    localparam int BCD_DIGITS    = 20;                       // 19 digits, padded to even
    localparam int BCD_W         = BCD_DIGITS * 4;
    localparam int PAIRS         = BCD_DIGITS / 2;           // two digits per digit step
    localparam int CNT_W         = 4;                        // loop counter
    localparam int DCNT_W        = 5;                        // digit count
    localparam int SUM_W         = 8;                        // Luhn sum, max 171
    localparam int CLASS_W       = 2;
    localparam int PC_W          = 2;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_INVALID    = 2'd0,
        CLASS_AMEX       = 2'd1,
        CLASS_MASTERCARD = 2'd2,
        CLASS_VISA       = 2'd3
    } t_card_class;

    // Datapath operation selected by the control word
    typedef enum logic [1:0] {
        OP_IDLE,
        OP_DABBLE,
        OP_DIGIT,
        OP_EMIT
    } t_op;

    // Jump condition
    typedef enum logic [1:0] {
        COND_IN_VALID,
        COND_CNT_LAST,
        COND_OUT_FREE,
        COND_ALWAYS
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    // Program addresses
    localparam t_pc PC_IDLE   = 2'd0;
    localparam t_pc PC_DABBLE = 2'd1;
    localparam t_pc PC_DIGIT  = 2'd2;
    localparam t_pc PC_EMIT   = 2'd3;

    // One control word: when cond holds, jump and reload the loop counter
    typedef struct packed {
        t_op              op;
        t_cond            cond;
        t_pc              jump;
        logic [CNT_W-1:0] cnt_init;
    } t_ctl;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic cnt_last;
        logic out_free;
    } t_status;

    // Add-3 correction on every BCD digit, then shift in one binary bit
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                     input logic            b);
        logic [BCD_W-1:0] adj;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3
                                                    : bcd[4*k +: 4];
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Luhn doubling: 2d, or 2d-9 when that reaches ten
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] twice;
        twice = {d, 1'b0};
        return (d >= 4'd5) ? 4'(twice - 5'd9) : twice[3:0];
    endfunction

    // Sum is a multiple of ten (compare against every multiple in range)
    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * 10 < (1 << SUM_W); k++) begin
            if (s == SUM_W'(k * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* hw/rtl/luhn_card_classifier.sv */
// ----------------------------------------------------------------------------
// luhn_card_classifier
// Luhn mod-10 check and issuer class of one binary card number.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | transaction
//  --------+-------------------------------------------+-----+------------------
//  in      | i_in_valid, o_in_ready, i_card_number     | in  | one card number
//  out     | o_out_valid, i_out_ready, o_card_class,   | out | one result per
//          | o_luhn_ok, o_digit_count                  |     | input
//
//  Each transaction runs one accept step, 16 conversion steps (4 bits each
//  into a 20-digit BCD register), 10 digit-pair steps of the Luhn sum and
//  one emit step. The microcode loop counter sets these figures.
//  Synchronous active-low reset clears the program counter and the result
//  valid flag; no clearing pass.
//  A finished result sits in the output register; the next transaction is
//  accepted while it waits. Emit stalls only if the previous result is unread.
//
module luhn_card_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lcc_pkg::CARD_W-1:0]    i_card_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lcc_pkg::CLASS_W-1:0]   o_card_class,
    output logic                          o_luhn_ok,
    output logic [lcc_pkg::DCNT_W-1:0]    o_digit_count
);
    import lcc_pkg::*;

    // Control word of the current step and whether its jump is taken
    t_ctl    ctl;
    logic    taken;
    t_status status;

    // Program counter + control store
    lcc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl),
        .o_taken  (taken)
    );

    // Double-dabble shifter, digit-pair accumulator, result register
    lcc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_taken       (taken),
        .o_status      (status),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_card_number (i_card_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_card_class  (o_card_class),
        .o_luhn_ok     (o_luhn_ok),
        .o_digit_count (o_digit_count)
    );

endmodule

/* hw/rtl/lcc_sequencer.sv */
// ----------------------------------------------------------------------------
// lcc_sequencer
// Program counter and control store; one control word per step.
// ----------------------------------------------------------------------------
module lcc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcc_pkg::t_status i_status,
    output lcc_pkg::t_ctl    o_ctl,
    output logic             o_taken
);
    import lcc_pkg::*;

    t_pc  r_pc;
    t_pc  n_pc;
    t_ctl ctl;
    logic taken;

    // Control store
    always_comb begin
        unique case (r_pc)
            PC_IDLE:   ctl = '{op: OP_IDLE,   cond: COND_IN_VALID, jump: PC_DABBLE,
                               cnt_init: CNT_W'(DABBLE_STEPS - 1)};
            PC_DABBLE: ctl = '{op: OP_DABBLE, cond: COND_CNT_LAST, jump: PC_DIGIT,
                               cnt_init: CNT_W'(PAIRS - 1)};
            PC_DIGIT:  ctl = '{op: OP_DIGIT,  cond: COND_CNT_LAST, jump: PC_EMIT,
                               cnt_init: '0};
            PC_EMIT:   ctl = '{op: OP_EMIT,   cond: COND_OUT_FREE, jump: PC_IDLE,
                               cnt_init: '0};
            default:   ctl = '{op: OP_IDLE,   cond: COND_ALWAYS,   jump: PC_IDLE,
                               cnt_init: '0};
        endcase
    end

    // Condition select
    always_comb begin
        unique case (ctl.cond)
            COND_IN_VALID: taken = i_status.in_valid;
            COND_CNT_LAST: taken = i_status.cnt_last;
            COND_OUT_FREE: taken = i_status.out_free;
            COND_ALWAYS:   taken = 1'b1;
            default:       taken = 1'b1;
        endcase
    end

    // Jump on condition, otherwise repeat the step
    always_comb begin
        n_pc = taken ? ctl.jump : r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl   = ctl;
    assign o_taken = taken;

endmodule

/* hw/rtl/lcc_datapath.sv */
// ----------------------------------------------------------------------------
// lcc_datapath
// Binary-to-BCD shifter, digit-pair Luhn accumulator and result register.
// ----------------------------------------------------------------------------
module lcc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcc_pkg::t_ctl                 i_ctl,
    input  logic                          i_taken,
    output lcc_pkg::t_status              o_status,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lcc_pkg::CARD_W-1:0]    i_card_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lcc_pkg::CLASS_W-1:0]   o_card_class,
    output logic                          o_luhn_ok,
    output logic [lcc_pkg::DCNT_W-1:0]    o_digit_count
);
    import lcc_pkg::*;

    logic [BIN_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic [DCNT_W-1:0]  r_pos;      // digit position of the current low digit
    logic [DCNT_W-1:0]  r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [3:0]         r_lead;
    logic [3:0]         r_next;
    logic [3:0]         r_prev;     // high digit of the previous pair

    logic               r_out_valid;
    t_card_class        r_class;
    logic               r_ok;
    logic [DCNT_W-1:0]  r_dcount;

    logic [BCD_W-1:0]   bcd_work;
    logic [3:0]         lo;
    logic [3:0]         hi;
    logic [SUM_W-1:0]   n_sum;
    logic               ok;
    t_card_class        cls;
    logic               out_free;
    logic [CNT_W-1:0]   n_cnt;

    // Four chained dabble bits per step, MSB first
    always_comb begin
        bcd_work = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            bcd_work = dabble_bit(bcd_work, r_bin[BIN_W-1-k]);
        end
    end

    assign lo    = r_bcd[3:0];
    assign hi    = r_bcd[7:4];
    assign n_sum = r_sum + SUM_W'(lo) + SUM_W'(luhn_dbl(hi));
    assign n_cnt = i_taken ? i_ctl.cnt_init : r_cnt - CNT_W'(1);

    // Classification from the finished sums
    always_comb begin
        ok  = is_mult10(r_sum);
        cls = CLASS_INVALID;
        if (ok) begin
            if (r_count == DCNT_W'(15) && r_lead == 4'd3 &&
                (r_next == 4'd4 || r_next == 4'd7)) begin
                cls = CLASS_AMEX;
            end else if ((r_count == DCNT_W'(13) || r_count == DCNT_W'(16)) &&
                         r_lead == 4'd4) begin
                cls = CLASS_VISA;
            end else if (r_count == DCNT_W'(16) && r_lead == 4'd5 &&
                         r_next >= 4'd1 && r_next <= 4'd5) begin
                cls = CLASS_MASTERCARD;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.in_valid = i_in_valid;
        o_status.cnt_last = (r_cnt == '0);
        o_status.out_free = out_free;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_IDLE: begin
                if (i_taken) begin
                    r_bin   <= BIN_W'(i_card_number);
                    r_bcd   <= '0;
                    r_cnt   <= i_ctl.cnt_init;
                    r_pos   <= '0;
                    r_count <= '0;
                    r_sum   <= '0;
                    r_lead  <= '0;
                    r_next  <= '0;
                    r_prev  <= '0;
                end
            end
            OP_DABBLE: begin
                r_bcd <= bcd_work;
                r_bin <= r_bin << BITS_PER_STEP;
                r_cnt <= n_cnt;
            end
            OP_DIGIT: begin
                r_bcd <= r_bcd >> 8;
                r_cnt <= n_cnt;
                r_sum <= n_sum;
                r_pos <= r_pos + DCNT_W'(2);
                r_prev <= hi;
                if (hi != 4'd0) begin
                    r_count <= r_pos + DCNT_W'(2);
                    r_lead  <= hi;
                    r_next  <= lo;
                end else if (lo != 4'd0) begin
                    r_count <= r_pos + DCNT_W'(1);
                    r_lead  <= lo;
                    r_next  <= r_prev;
                end
            end
            OP_EMIT: begin
                if (i_taken) begin
                    r_class  <= cls;
                    r_ok     <= ok;
                    r_dcount <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_EMIT && i_taken) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready    = (i_ctl.op == OP_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_card_class  = r_class;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_dcount;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the Luhn card classifier
// Drives binary card numbers through the valid/ready input channel and checks
// every result transaction against a scoreboard built from a behavioral
// classifier. Directed corner cards come first, then about 700 random cards,
// under half of them well-formed card numbers of each brand.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam int NUM_RANDOM   = 700;
    localparam int QUIET_TAIL   = 80;         // last cards go out with no idling
    localparam int SETTLE_CYC   = 60;         // longer than one full transaction
    localparam int MAX_REPORTS  = 10;

    // One result transaction as the block reports it
    typedef struct packed {
        t_card_class           card_class;
        logic                  luhn_ok;
        logic [DCNT_W-1:0]     digit_count;
    } t_card_verdict;

    // One card waiting to go out; drain_first holds it back until the
    // scoreboard is empty
    typedef struct {
        logic [CARD_W-1:0]     number;
        bit                    drain_first;
    } t_card_item;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CARD_W-1:0]     card_number = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic [CLASS_W-1:0]    o_card_class;
    logic                  o_luhn_ok;
    logic [DCNT_W-1:0]     o_digit_count;

    t_card_item            pending_cards[$];
    t_card_verdict         predicted_verdicts[$];

    logic [15:0]           cycle_count = '0;
    int                    gap_left = 0;
    int                    stall_left = 0;
    int                    cards_sent = 0;
    int                    verdicts_seen = 0;
    int                    mismatches = 0;
    int                    luhn_failures = 0;
    int                    class_seen[4] = '{0, 0, 0, 0};

    luhn_card_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_card_number  (card_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_card_class   (o_card_class),
        .o_luhn_ok      (o_luhn_ok),
        .o_digit_count  (o_digit_count)
    );

    // ------------------------------------------------------------------
    // Behavioral classifier
    // ------------------------------------------------------------------

    // Walk the digits from the right: every second one is doubled, and a
    // doubled value of ten or more counts as its digit sum (minus nine).
    // The two last digits peeled off are the leading pair of the number.
    function automatic t_card_verdict classify_card(input logic [CARD_W-1:0] number);
        logic [63:0]    rest;
        int unsigned    digit;
        int unsigned    total;
        int unsigned    count;
        int unsigned    lead;
        int unsigned    second;
        int unsigned    prefix;
        t_card_verdict  verdict;
        rest   = {1'b0, number};
        total  = 0;
        count  = 0;
        lead   = 0;
        second = 0;
        while (rest != 64'd0) begin
            digit  = int'(rest % 64'd10);
            rest   = rest / 64'd10;
            second = lead;
            lead   = digit;
            if (count % 2 == 1) begin
                digit = digit * 2;
                if (digit >= 10) begin
                    digit = digit - 9;
                end
            end
            total = total + digit;
            count = count + 1;
        end
        verdict.luhn_ok     = (total % 10 == 0);
        verdict.digit_count = DCNT_W'(count);
        verdict.card_class  = CLASS_INVALID;
        prefix = lead * 10 + second;
        if (verdict.luhn_ok) begin
            if (count == 15 && (prefix == 34 || prefix == 37)) begin
                verdict.card_class = CLASS_AMEX;
            end else if ((count == 13 || count == 16) && lead == 4) begin
                verdict.card_class = CLASS_VISA;
            end else if (count == 16 && prefix >= 51 && prefix <= 55) begin
                verdict.card_class = CLASS_MASTERCARD;
            end
        end
        return verdict;
    endfunction

    // ------------------------------------------------------------------
    // Card number generators
    // ------------------------------------------------------------------

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // n-digit card with the given leading digits and a correct check digit
    function automatic logic [CARD_W-1:0] make_card(input int prefix, input int plen,
                                                    input int n);
        logic [63:0]   scale;
        logic [63:0]   body;
        t_card_verdict trial;
        scale = pow10(n - plen);
        body  = 64'(prefix) * scale + rand64() % scale;
        body  = body - body % 64'd10;
        for (int d = 0; d < 10; d++) begin
            trial = classify_card(CARD_W'(body + 64'(d)));
            if (trial.luhn_ok) begin
                return CARD_W'(body + 64'(d));
            end
        end
        return CARD_W'(body);
    endfunction

    // Shifting the check digit by one always breaks the sum
    function automatic logic [CARD_W-1:0] break_luhn(input logic [CARD_W-1:0] number);
        return (number % 10 == 9) ? number - 1'b1 : number + 1'b1;
    endfunction

    // Any n-digit number, 19 digits capped at the 63-bit range
    function automatic logic [CARD_W-1:0] random_length(input int n);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = pow10(n - 1);
        hi = (n == 19) ? 64'h8000_0000_0000_0000 : lo * 64'd10;
        return CARD_W'(lo + rand64() % (hi - lo));
    endfunction

    // Well-formed card of a random brand
    function automatic logic [CARD_W-1:0] random_brand_card();
        case ($urandom_range(0, 3))
            0: return make_card($urandom_range(0, 1) ? 37 : 34, 2, 15);
            1: return make_card(4, 1, $urandom_range(0, 1) ? 16 : 13);
            2: return make_card($urandom_range(51, 55), 2, 16);
            default: return make_card(4, 1, 16);
        endcase
    endfunction

    task automatic add_card(input logic [CARD_W-1:0] number, input bit drain_first);
        t_card_item item;
        item.number      = number;
        item.drain_first = drain_first;
        pending_cards.push_back(item);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: feeds pending_cards onto the input channel. Once valid is up
    // it stays up with the same card until the transaction is taken.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            // Accepted card: predict its verdict now, in input order
            if (in_valid && o_in_ready) begin
                predicted_verdicts.push_back(classify_card(card_number));
                pending_cards.delete(0);
                cards_sent++;
            end
            if (in_valid && !o_in_ready) begin
                // held: payload must not move
            end else if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (pending_cards.size() == 0) begin
                in_valid <= 1'b0;
            end else if (pending_cards[0].drain_first && predicted_verdicts.size() != 0) begin
                // let the block empty out completely before this card
                in_valid <= 1'b0;
            end else if (pending_cards.size() > QUIET_TAIL && cycle_count[7:6] != 2'b00
                         && $urandom_range(0, 7) == 0) begin
                // idle burst of random length, counted down in gap_left
                in_valid <= 1'b0;
                gap_left = $urandom_range(0, 3);
            end else begin
                in_valid    <= 1'b1;
                card_number <= pending_cards[0].number;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result transactions, compares each field with the
    // oldest prediction, and throttles out_ready in random bursts.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_card_verdict want;
        t_card_verdict got;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                got.card_class  = t_card_class'(o_card_class);
                got.luhn_ok     = o_luhn_ok;
                got.digit_count = o_digit_count;
                verdicts_seen++;
                if (predicted_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: class %0d luhn_ok %0d digits %0d",
                                 $realtime, got.card_class, got.luhn_ok, got.digit_count);
                    end
                end else begin
                    want = predicted_verdicts.pop_front();
                    class_seen[want.card_class]++;
                    if (!want.luhn_ok) begin
                        luhn_failures++;
                    end
                    if (got.card_class !== want.card_class || got.luhn_ok !== want.luhn_ok
                        || got.digit_count !== want.digit_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("[%0t] result %0d mismatch: ", $realtime, verdicts_seen);
                            $display(
                                "class %0d/%0d luhn_ok %0d/%0d digits %0d/%0d (expected/actual)",
                                want.card_class, got.card_class,
                                want.luhn_ok, got.luhn_ok,
                                want.digit_count, got.digit_count);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (pending_cards.size() > QUIET_TAIL && cycle_count[8:7] != 2'b11
                         && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        int            pick;
        logic [CARD_W-1:0] number;

        // Directed corners
        add_card('0, 1'b0);                              // zero: no digits, sum 0
        add_card({CARD_W{1'b1}}, 1'b0);                  // largest input, 19 digits
        add_card(CARD_W'(1), 1'b0);
        add_card(CARD_W'(4), 1'b0);                      // lone visa digit
        add_card(CARD_W'(pow10(18)), 1'b0);              // smallest 19-digit
        add_card(CARD_W'(pow10(18) - 1), 1'b0);          // eighteen nines
        add_card(make_card(34, 2, 15), 1'b0);            // amex
        add_card(make_card(37, 2, 15), 1'b0);
        add_card(make_card(34, 2, 16), 1'b0);            // amex prefix, wrong length
        add_card(make_card(35, 2, 15), 1'b0);            // amex length, wrong prefix
        add_card(break_luhn(make_card(37, 2, 15)), 1'b0);
        add_card(make_card(4, 1, 13), 1'b0);             // visa, both lengths
        add_card(make_card(4, 1, 16), 1'b0);
        add_card(make_card(4, 1, 14), 1'b0);
        add_card(make_card(4, 1, 15), 1'b0);
        add_card(break_luhn(make_card(4, 1, 16)), 1'b0);
        add_card(make_card(51, 2, 16), 1'b0);            // mastercard range ends
        add_card(make_card(55, 2, 16), 1'b0);
        add_card(make_card(50, 2, 16), 1'b0);            // just outside the range
        add_card(make_card(56, 2, 16), 1'b0);
        add_card(make_card(51, 2, 15), 1'b0);
        add_card(break_luhn(make_card(53, 2, 16)), 1'b0);
        add_card(make_card(4, 1, 19), 1'b0);

        // Random part; the block is drained completely twice on the way
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                number = random_brand_card();
            end else if (pick < 60) begin
                number = break_luhn(random_brand_card());
            end else if (pick < 70) begin
                // near misses: any two-digit prefix, lengths around the brand ones
                number = make_card($urandom_range(10, 99), 2, $urandom_range(12, 17));
            end else if (pick < 85) begin
                number = random_length($urandom_range(1, 19));
            end else begin
                number = CARD_W'(rand64());
            end
            add_card(number, i == 0 || i == NUM_RANDOM / 2);
        end

        wait (i_rst_n === 1'b1);
        while (pending_cards.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (predicted_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (predicted_verdicts.size() != 0) begin
            mismatches++;
        end
        $display("Classified %0d card numbers: %0d amex, %0d mastercard, %0d visa, %0d invalid.",
                 verdicts_seen, class_seen[CLASS_AMEX], class_seen[CLASS_MASTERCARD],
                 class_seen[CLASS_VISA], class_seen[CLASS_INVALID]);
        $display("%0d of them failed the Luhn sum; %0d mismatches.", luhn_failures, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
